// ===== design/distance_to_midi_event_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// Distance-to-MIDI event tracker: assertion macros
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_TO_MIDI_EVENT_TRACKER_ASSERT_SVH
`define DISTANCE_TO_MIDI_EVENT_TRACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DTM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dtm_pkg.sv =====
// ----------------------------------------------------------------------------
// Distance-to-MIDI event tracker: package
// Message codes, mode codes, controller numbers, register indexes, reset values,
// FSM states and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package dtm_pkg;

  localparam int SENSOR_COUNT = 2;

  typedef enum logic [1:0] {
    MSG_CONV     = 2'd0,
    MSG_NOTE_OFF = 2'd1,
    MSG_NOTE_ON  = 2'd2,
    MSG_CTRL     = 2'd3
  } msg_t;

  localparam logic [1:0] MODE_NOTES    = 2'd0;
  localparam logic [1:0] MODE_CTRL_ONE = 2'd1;
  localparam logic [1:0] MODE_CTRL_TWO = 2'd2;
  localparam logic [1:0] MODE_SILENT   = 2'd3;

  localparam logic [6:0] CTRL_ONE_NUM = 7'h66;
  localparam logic [6:0] CTRL_TWO_NUM = 7'h67;

  localparam logic [2:0] CFG_MIN_DIST = 3'd0;
  localparam logic [2:0] CFG_MAX_DIST = 3'd1;
  localparam logic [2:0] CFG_BIN_DIV  = 3'd2;
  localparam logic [2:0] CFG_MODE_0   = 3'd3;
  localparam logic [2:0] CFG_MODE_1   = 3'd4;
  localparam logic [2:0] CFG_CUTOFF   = 3'd5;

  localparam logic [7:0] RST_MIN_DIST = 8'd10;
  localparam logic [7:0] RST_MAX_DIST = 8'd200;
  localparam logic [7:0] RST_BIN_DIV  = 8'd10;
  localparam logic [9:0] RST_CUTOFF   = 10'd40;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_CUR_GO,
    ST_CUR_RUN,
    ST_PREV_GO,
    ST_PREV_RUN,
    ST_CMP,
    ST_OFF,
    ST_ON
  } state_t;

  typedef struct packed {
    logic load_item;
    logic tick_done;
    logic div_start;
    logic div_sel_prev;
    logic cap_cur;
    logic cap_prev;
    logic set_next;
    logic clr_stored;
    logic wr_stored;
    logic emit;
    msg_t emit_msg;
    logic emit_last;
  } dtm_cmd_t;

  typedef struct packed {
    logic       hit;
    logic       div_done;
    logic       stored_nz;
    logic       same_bin;
    logic       in_range;
    logic [1:0] mode;
    logic       out_free;
  } dtm_sts_t;

endpackage

// ===== design/dtm_div.sv =====
// ----------------------------------------------------------------------------
// Distance-to-MIDI event tracker: bin divider
// Restoring divider, one quotient bit a cycle, eight quotient bits per bin.
// Works on |d - min| and negates the quotient for distances below min.
// ----------------------------------------------------------------------------
module dtm_div (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] dist_in,
  input  logic [7:0] min_dist,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] bin
);

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] q_r, q_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] dv_r, dv_nxt;
  logic       neg_r, neg_nxt;

  logic [8:0] diff;
  logic [8:0] diff_neg;
  logic [8:0] trial;
  logic       ge;

  always_comb begin
    diff     = {1'b0, dist_in} - {1'b0, min_dist};
    diff_neg = ~diff + 9'd1;
    trial    = {rem_r, q_r[7]};
    ge       = (trial >= {1'b0, dv_r});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    neg_nxt  = neg_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      neg_nxt  = diff[8];
      q_nxt    = diff[8] ? diff_neg[7:0] : diff[7:0];
      // a zero divisor counts as one
      dv_nxt   = (divisor == 8'd0) ? 8'd1 : divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? 8'(trial - {1'b0, dv_r}) : trial[7:0];
      q_nxt   = {q_r[6:0], ge};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign bin  = neg_r ? (~q_r + 8'd1) : q_r;

endmodule

// ===== design/dtm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Distance-to-MIDI event tracker: controller
// Sequences one item at a time: tick handling, one or two bin divisions,
// and up to two result beats.
// ----------------------------------------------------------------------------
module dtm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_kind,
  output logic              in_tready,
  input  dtm_pkg::dtm_sts_t sts,
  output dtm_pkg::dtm_cmd_t cmd
);

  import dtm_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = in_kind ? ST_CUR_GO : ST_TICK;
      end
      ST_TICK: begin
        if (!sts.hit || sts.out_free) state_nxt = ST_IDLE;
      end
      ST_CUR_GO:  state_nxt = ST_CUR_RUN;
      ST_CUR_RUN: begin
        if (sts.div_done) state_nxt = sts.stored_nz ? ST_PREV_GO : ST_ON;
      end
      ST_PREV_GO:  state_nxt = ST_PREV_RUN;
      ST_PREV_RUN: begin
        if (sts.div_done) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (sts.same_bin)                 state_nxt = ST_IDLE;
        else if (sts.mode == MODE_NOTES)  state_nxt = ST_OFF;
        else                              state_nxt = ST_ON;
      end
      ST_OFF: begin
        if (sts.out_free) state_nxt = ST_ON;
      end
      ST_ON: begin
        if (!sts.in_range || sts.mode == MODE_SILENT || sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.load_item = in_tvalid;
      end
      ST_TICK: begin
        if (!sts.hit) begin
          cmd.tick_done = 1'b1;
        end else if (sts.out_free) begin
          cmd.tick_done = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_msg  = MSG_CONV;
          cmd.emit_last = 1'b1;
        end
      end
      ST_CUR_GO: begin
        cmd.div_start = 1'b1;
        cmd.set_next  = 1'b1;
      end
      ST_CUR_RUN: cmd.cap_cur = sts.div_done;
      ST_PREV_GO: begin
        cmd.div_start    = 1'b1;
        cmd.div_sel_prev = 1'b1;
      end
      ST_PREV_RUN: cmd.cap_prev = sts.div_done;
      ST_CMP: cmd.clr_stored = !sts.same_bin;
      ST_OFF: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_msg  = MSG_NOTE_OFF;
          // only note mode reaches here, so a note-on follows when in range
          cmd.emit_last = !sts.in_range;
        end
      end
      ST_ON: begin
        if (sts.in_range) begin
          if (sts.mode == MODE_SILENT) begin
            cmd.wr_stored = 1'b1;
          end else if (sts.out_free) begin
            cmd.wr_stored = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_msg  = (sts.mode == MODE_NOTES) ? MSG_NOTE_ON : MSG_CTRL;
            cmd.emit_last = 1'b1;
          end
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/dtm_dp.sv =====
// ----------------------------------------------------------------------------
// Distance-to-MIDI event tracker: datapath
// Config registers, item registers, tick accumulator, stored distances,
// bin divider and the output beat register.
// ----------------------------------------------------------------------------
module dtm_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [9:0]        cfg_wdata,
  input  logic [7:0]        in_tick_ms,
  input  logic              in_sensor_index,
  input  logic [9:0]        in_raw_sample,
  output logic              out_tvalid,
  input  logic              out_tready,
  output dtm_pkg::msg_t     out_message,
  output logic              out_target_sensor,
  output logic [7:0]        out_bin_index,
  output logic [6:0]        out_controller_number,
  output logic [1:0]        out_enable_pins,
  output logic              out_last,
  input  dtm_pkg::dtm_cmd_t cmd,
  output dtm_pkg::dtm_sts_t sts
);

  import dtm_pkg::*;

  // configuration
  logic [7:0] min_r, max_r, div_r;
  logic [1:0] mode0_r, mode1_r;
  logic [9:0] cutoff_r;

  // item and working state
  logic [7:0]  tick_r;
  logic        ch_r;
  logic [7:0]  dist_r;
  logic [15:0] acc_r, acc_nxt;
  logic        next_sensor_r;
  logic [7:0]  stored_r [SENSOR_COUNT];
  logic [7:0]  cur_r, prev_r;

  // output beat
  logic       out_valid_r, out_valid_nxt;
  msg_t       out_msg_r;
  logic       out_tgt_r;
  logic [7:0] out_bin_r;
  logic [6:0] out_ctrl_r;
  logic [1:0] out_en_r;
  logic       out_last_r;

  logic [15:0] acc_sum;
  logic        hit;
  logic [1:0]  mode;
  logic [7:0]  div_operand;
  logic        div_done;
  logic [7:0]  div_bin;
  logic        out_free;
  logic        emit_tgt;
  logic [7:0]  emit_bin;
  logic [6:0]  emit_ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= RST_MIN_DIST;
      max_r    <= RST_MAX_DIST;
      div_r    <= RST_BIN_DIV;
      mode0_r  <= MODE_NOTES;
      mode1_r  <= MODE_NOTES;
      cutoff_r <= RST_CUTOFF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MIN_DIST: min_r    <= cfg_wdata[7:0];
        CFG_MAX_DIST: max_r    <= cfg_wdata[7:0];
        CFG_BIN_DIV:  div_r    <= cfg_wdata[7:0];
        CFG_MODE_0:   mode0_r  <= cfg_wdata[1:0];
        CFG_MODE_1:   mode1_r  <= cfg_wdata[1:0];
        CFG_CUTOFF:   cutoff_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      tick_r <= in_tick_ms;
      ch_r   <= in_sensor_index;
      dist_r <= in_raw_sample[8:1];
    end
    if (cmd.cap_cur)  cur_r  <= div_bin;
    if (cmd.cap_prev) prev_r <= div_bin;
  end

  assign acc_sum = acc_r + {8'd0, tick_r};
  assign hit     = (acc_sum >= {6'd0, cutoff_r});
  assign acc_nxt = cmd.tick_done ? (hit ? 16'd0 : acc_sum) : acc_r;

  assign mode        = ch_r ? mode1_r : mode0_r;
  assign div_operand = cmd.div_sel_prev ? stored_r[ch_r] : dist_r;

  dtm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dist_in  (div_operand),
    .min_dist (min_r),
    .divisor  (div_r),
    .done     (div_done),
    .bin      (div_bin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r         <= '0;
      next_sensor_r <= 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) stored_r[i] <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (cmd.set_next) next_sensor_r <= ~ch_r;
      if (cmd.wr_stored)       stored_r[ch_r] <= dist_r;
      else if (cmd.clr_stored) stored_r[ch_r] <= '0;
    end
  end

  // result fields for the beat being loaded
  always_comb begin
    emit_tgt  = ch_r;
    emit_bin  = cur_r;
    emit_ctrl = '0;
    unique case (cmd.emit_msg)
      MSG_CONV: begin
        emit_tgt = next_sensor_r;
        emit_bin = '0;
      end
      MSG_NOTE_OFF: emit_bin = prev_r;
      MSG_NOTE_ON:  emit_bin = cur_r;
      MSG_CTRL:     emit_ctrl = (mode == MODE_CTRL_ONE) ? CTRL_ONE_NUM : CTRL_TWO_NUM;
      default:      emit_bin = cur_r;
    endcase
  end

  assign out_free      = !out_valid_r || out_tready;
  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_msg_r  <= cmd.emit_msg;
      out_tgt_r  <= emit_tgt;
      out_bin_r  <= emit_bin;
      out_ctrl_r <= emit_ctrl;
      out_en_r   <= {next_sensor_r, ~next_sensor_r};
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_tvalid            = out_valid_r;
  assign out_message           = out_msg_r;
  assign out_target_sensor     = out_tgt_r;
  assign out_bin_index         = out_bin_r;
  assign out_controller_number = out_ctrl_r;
  assign out_enable_pins       = out_en_r;
  assign out_last              = out_last_r;

  assign sts.hit       = hit;
  assign sts.div_done  = div_done;
  assign sts.stored_nz = (stored_r[ch_r] != 8'd0);
  assign sts.same_bin  = (prev_r == cur_r);
  assign sts.in_range  = (dist_r >= min_r) && (dist_r < max_r);
  assign sts.mode      = mode;
  assign sts.out_free  = out_free;

endmodule

// ===== design/distance_to_midi_event_tracker.sv =====
// Tick beat: the tick state adds tick_ms to the accumulator and, on a hit, loads
// the start-conversion beat into the output register once it is free. Sample beat:
// the eight-step bin divider runs for the new distance and again for a stored one.
// One item is in flight; a new item is taken while the last result beat still waits.
// rst_n is synchronous and active low: registers return to their defaults, stored
// distances and the tick accumulator clear and sensor 0 is enabled.
// ----------------------------------------------------------------------------
// Distance-to-MIDI event tracker: top level
// Turns timer ticks into conversion requests and distance samples from two
// alternating sensors into note-off, note-on and control-change events.
// ----------------------------------------------------------------------------
module distance_to_midi_event_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // tick_ms[7:0], sensor_index[8], raw_sample[18:9], zero pad
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // target_sensor[0], bin_index[8:1],
                                  // controller_number[15:9], enable_pins[17:16], zero pad
  output logic [1:0]  out_tuser,  // message
  output logic        out_tlast
);

  import dtm_pkg::*;

  dtm_cmd_t   cmd;
  dtm_sts_t   sts;
  msg_t       out_message;
  logic       out_target_sensor;
  logic [7:0] out_bin_index;
  logic [6:0] out_controller_number;
  logic [1:0] out_enable_pins;

  dtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtm_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_addr              (cfg_addr),
    .cfg_wdata             (cfg_wdata),
    .in_tick_ms            (in_tdata[7:0]),
    .in_sensor_index       (in_tdata[8]),
    .in_raw_sample         (in_tdata[18:9]),
    .out_tvalid            (out_tvalid),
    .out_tready            (out_tready),
    .out_message           (out_message),
    .out_target_sensor     (out_target_sensor),
    .out_bin_index         (out_bin_index),
    .out_controller_number (out_controller_number),
    .out_enable_pins       (out_enable_pins),
    .out_last              (out_tlast),
    .cmd                   (cmd),
    .sts                   (sts)
  );

  assign out_tuser = out_message;
  assign out_tdata = {6'd0, out_enable_pins, out_controller_number, out_bin_index,
                      out_target_sensor};

endmodule

// ===== design/dtm_checker.sv =====
// ----------------------------------------------------------------------------
// Distance-to-MIDI event tracker: port checker
// Watches the result channel of the top level; bound in below.
// ----------------------------------------------------------------------------
`include "distance_to_midi_event_tracker_assert.svh"

module dtm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  import dtm_pkg::*;

  `DTM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result beat changed while stalled")

  `DTM_ASSERT_SAME(a_conv_shape, out_tvalid && out_tuser == MSG_CONV, out_tlast && out_tdata[15:1] == 15'd0, "start conversion beat not last or carries bin data")

  `DTM_ASSERT_SAME(a_enable_onehot, out_tvalid, $onehot(out_tdata[17:16]), "enable pins not one-hot")

  `DTM_ASSERT_SAME(a_ctrl_number, out_tvalid && out_tuser == MSG_CTRL, out_tlast && (out_tdata[15:9] == CTRL_ONE_NUM || out_tdata[15:9] == CTRL_TWO_NUM), "control change beat with bad controller number")

endmodule

bind distance_to_midi_event_tracker dtm_checker u_dtm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== bench/tb_distance_to_midi_event_tracker.sv =====
// ----------------------------------------------------------------------------
// Distance-to-MIDI event tracker: self-checking bench
// Streams timer ticks and sensor samples through the tracker over several
// register settings, predicts every conversion request and MIDI event, and
// compares each output beat with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_distance_to_midi_event_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import dtm_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic       kind;
    logic [7:0] tick_ms;
    logic       sensor;
    logic [9:0] raw;
  } sensor_item_t;

  typedef struct {
    msg_t       msg;
    logic       target;
    logic [7:0] bin_idx;
    logic [6:0] ctrl;
    logic [1:0] pins;
    logic       last;
  } midi_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [9:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // tick_ms[7:0], sensor_index[8], raw_sample[18:9], pad
  logic        in_tuser = 1'b0; // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // target_sensor[0], bin_index[8:1],
                                // controller_number[15:9], enable_pins[17:16], pad
  logic [1:0]  out_tuser;       // message
  logic        out_tlast;

  distance_to_midi_event_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of registers and state
  logic [7:0]  min_dist_r = RST_MIN_DIST;
  logic [7:0]  max_dist_r = RST_MAX_DIST;
  logic [7:0]  bin_div_r  = RST_BIN_DIV;
  logic [9:0]  cutoff_r   = RST_CUTOFF;
  logic [1:0]  mode_r [SENSOR_COUNT] = '{MODE_NOTES, MODE_NOTES};
  logic [7:0]  held_dist [SENSOR_COUNT] = '{8'd0, 8'd0};
  logic [15:0] ms_acc = '0;
  logic        next_ch = 1'b0;

  sensor_item_t sensor_items[$];
  midi_event_t  midi_due[$];
  int           items_queued = 0;
  int           items_taken = 0;
  int           errors = 0;
  int           cycles = 0;
  bit           no_idle = 1'b0;

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // bin relative to min_distance, truncated toward zero, mod 256
  function automatic logic [7:0] dist_bin(logic [7:0] d);
    int diff;
    int q;
    diff = int'(d) - int'(min_dist_r);
    q = diff / ((bin_div_r == 8'd0) ? 1 : int'(bin_div_r));
    return q[7:0];
  endfunction

  function automatic midi_event_t make_event(msg_t m, logic t, logic [7:0] b, logic [6:0] c);
    midi_event_t e;
    e.msg = m;
    e.target = t;
    e.bin_idx = b;
    e.ctrl = c;
    e.pins = next_ch ? 2'b10 : 2'b01;
    e.last = 1'b0;
    return e;
  endfunction

  function automatic void predict_midi(sensor_item_t it);
    midi_event_t ev [2];
    int         n;
    logic       ch;
    logic [7:0] dist_val;
    logic [7:0] cur;
    logic [7:0] prev;
    logic [1:0] mode;
    bit         go;
    n = 0;
    if (!it.kind) begin
      ms_acc = ms_acc + 16'(it.tick_ms);
      if (ms_acc >= 16'(cutoff_r)) begin
        ms_acc = '0;
        ev[n] = make_event(MSG_CONV, next_ch, 8'd0, 7'd0);
        n++;
      end
    end else begin
      ch = it.sensor;
      dist_val = it.raw[8:1];
      mode = mode_r[ch];
      cur = dist_bin(dist_val);
      go = 1'b1;
      next_ch = ~ch;
      if (held_dist[ch] != 8'd0) begin
        prev = dist_bin(held_dist[ch]);
        if (prev == cur) begin
          go = 1'b0;
        end else begin
          if (mode == MODE_NOTES) begin
            ev[n] = make_event(MSG_NOTE_OFF, ch, prev, 7'd0);
            n++;
          end
          held_dist[ch] = 8'd0;
        end
      end
      if (go && dist_val >= min_dist_r && dist_val < max_dist_r) begin
        case (mode)
          MODE_NOTES: begin
            ev[n] = make_event(MSG_NOTE_ON, ch, cur, 7'd0);
            n++;
          end
          MODE_CTRL_ONE: begin
            ev[n] = make_event(MSG_CTRL, ch, cur, CTRL_ONE_NUM);
            n++;
          end
          MODE_CTRL_TWO: begin
            ev[n] = make_event(MSG_CTRL, ch, cur, CTRL_TWO_NUM);
            n++;
          end
          default: ;
        endcase
        held_dist[ch] = dist_val;
      end
    end
    for (int i = 0; i < n; i++) begin
      ev[i].last = (i == n - 1);
      midi_due.push_back(ev[i]);
    end
  endfunction

  // input driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) begin
        predict_midi(sensor_items.pop_front());
        items_taken++;
        in_gap = pause_len();
      end
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (sensor_items.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser <= sensor_items[0].kind;
        in_tdata <= {5'd0, sensor_items[0].raw, sensor_items[0].sensor,
                     sensor_items[0].tick_ms};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output monitor
  int out_gap = 0;
  always @(posedge clk) begin
    midi_event_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (midi_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected beat: msg=%0d tgt=%0d bin=%0d ctrl=%0h pins=%0d last=%0d",
                     out_tuser, out_tdata[0], out_tdata[8:1], out_tdata[15:9],
                     out_tdata[17:16], out_tlast);
        end else begin
          e = midi_due.pop_front();
          if (out_tuser != e.msg || out_tdata[0] != e.target ||
              out_tdata[8:1] != e.bin_idx || out_tdata[15:9] != e.ctrl ||
              out_tdata[17:16] != e.pins || out_tlast != e.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp msg=%0d tgt=%0d bin=%0d ctrl=%0h pins=%0d last=%0d | got msg=%0d tgt=%0d bin=%0d ctrl=%0h pins=%0d last=%0d",
                       e.msg, e.target, e.bin_idx, e.ctrl, e.pins, e.last,
                       out_tuser, out_tdata[0], out_tdata[8:1], out_tdata[15:9],
                       out_tdata[17:16], out_tlast);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap = pause_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic set_reg(logic [2:0] idx, logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MIN_DIST: min_dist_r = val[7:0];
      CFG_MAX_DIST: max_dist_r = val[7:0];
      CFG_BIN_DIV:  bin_div_r = val[7:0];
      CFG_MODE_0:   mode_r[0] = val[1:0];
      CFG_MODE_1:   mode_r[1] = val[1:0];
      CFG_CUTOFF:   cutoff_r = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_item(logic kind, logic [7:0] ms, logic ch, logic [9:0] raw);
    sensor_item_t it;
    it.kind = kind;
    it.tick_ms = ms;
    it.sensor = ch;
    it.raw = raw;
    sensor_items.push_back(it);
    items_queued++;
  endtask

  // every item taken, every event seen, then let an eventless item finish
  task automatic wait_idle();
    while (items_taken != items_queued || midi_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    int r;
    r = $urandom_range(0, 99);
    set_reg(CFG_MIN_DIST, (r < 10) ? 10'd0 : (r < 15) ? 10'd255 : 10'($urandom_range(0, 60)));
    r = $urandom_range(0, 99);
    set_reg(CFG_MAX_DIST, (r < 10) ? 10'd255 : (r < 15) ? 10'd0 :
                          10'($urandom_range(100, 255)));
    r = $urandom_range(0, 99);
    set_reg(CFG_BIN_DIV, (r < 5) ? 10'd0 : (r < 12) ? 10'd255 : (r < 20) ? 10'd1 :
                         10'($urandom_range(2, 40)));
    set_reg(CFG_MODE_0, 10'($urandom_range(0, 3)));
    set_reg(CFG_MODE_1, 10'($urandom_range(0, 3)));
    r = $urandom_range(0, 99);
    set_reg(CFG_CUTOFF, (r < 8) ? 10'd0 : (r < 14) ? 10'd1023 : 10'($urandom_range(1, 200)));
    end_writes();
  endtask

  // mostly tick/convert/sample cycles on the requested channel; some noise
  task automatic queue_traffic(int count);
    logic       gen_ch;
    logic [9:0] last_raw [2];
    int         added;
    int         v;
    int         r;
    gen_ch = next_ch;
    last_raw[0] = 10'($urandom_range(0, 1023));
    last_raw[1] = 10'($urandom_range(0, 1023));
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 99) < 80) begin
        repeat ($urandom_range(1, 3)) begin
          add_item(1'b0, 8'($urandom_range(0, 255)), 1'($urandom), 10'($urandom));
          added++;
        end
        r = $urandom_range(0, 99);
        if (r < 30)
          v = int'(last_raw[gen_ch]) + int'($urandom_range(0, 2)) - 1;
        else if (r < 70)
          v = int'(last_raw[gen_ch]) + int'($urandom_range(0, 80)) - 40;
        else
          v = $urandom_range(0, 1023);
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        last_raw[gen_ch] = 10'(v);
        add_item(1'b1, 8'($urandom), gen_ch, 10'(v));
        added++;
        gen_ch = ~gen_ch;
      end else begin
        add_item(1'($urandom), 8'($urandom), 1'($urandom), 10'($urandom));
        added++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: accumulator hit exactly at cutoff, note on/off paths
    add_item(1'b0, 8'd0, 1'b0, 10'd0);
    add_item(1'b0, 8'd39, 1'b1, 10'd1023);
    add_item(1'b0, 8'd1, 1'b0, 10'd0);
    add_item(1'b0, 8'd255, 1'b1, 10'd1023);
    add_item(1'b1, 8'd0, 1'b0, 10'd0);
    add_item(1'b1, 8'd255, 1'b0, 10'd100);
    add_item(1'b1, 8'd0, 1'b0, 10'd102);
    add_item(1'b1, 8'd0, 1'b0, 10'd1023);
    add_item(1'b1, 8'd0, 1'b1, 10'd40);
    add_item(1'b1, 8'd0, 1'b1, 10'd398);
    add_item(1'b1, 8'd0, 1'b1, 10'd400);
    add_item(1'b1, 8'd0, 1'b1, 10'd20);
    add_item(1'b1, 8'd0, 1'b0, 10'd512);
    wait_idle();

    // zero divisor, zero cutoff, both controllers, in-range zero distance
    set_reg(CFG_MIN_DIST, 10'd0);
    set_reg(CFG_MAX_DIST, 10'd255);
    set_reg(CFG_BIN_DIV, 10'd0);
    set_reg(CFG_MODE_0, 10'(MODE_CTRL_ONE));
    set_reg(CFG_MODE_1, 10'(MODE_CTRL_TWO));
    set_reg(CFG_CUTOFF, 10'd0);
    end_writes();
    add_item(1'b0, 8'd0, 1'b0, 10'd0);
    add_item(1'b1, 8'd0, 1'b0, 10'd0);
    add_item(1'b1, 8'd0, 1'b0, 10'd1);
    add_item(1'b1, 8'd0, 1'b1, 10'd510);
    add_item(1'b1, 8'd0, 1'b1, 10'd508);
    wait_idle();

    // empty range, widest divisor and cutoff; stored bin seen with new origin
    set_reg(CFG_MIN_DIST, 10'd20);
    set_reg(CFG_MAX_DIST, 10'd10);
    set_reg(CFG_BIN_DIV, 10'd255);
    set_reg(CFG_MODE_0, 10'(MODE_SILENT));
    set_reg(CFG_MODE_1, 10'(MODE_NOTES));
    set_reg(CFG_CUTOFF, 10'd1023);
    end_writes();
    repeat (5) add_item(1'b0, 8'd255, 1'b0, 10'd0);
    add_item(1'b1, 8'd0, 1'b1, 10'd100);
    add_item(1'b1, 8'd0, 1'b1, 10'd10);
    wait_idle();

    // silent mode still stores the distance
    set_reg(CFG_MIN_DIST, 10'd5);
    set_reg(CFG_MAX_DIST, 10'd250);
    set_reg(CFG_BIN_DIV, 10'd1);
    set_reg(CFG_CUTOFF, 10'd1);
    end_writes();
    add_item(1'b1, 8'd0, 1'b0, 10'd100);
    add_item(1'b1, 8'd0, 1'b0, 10'd120);
    add_item(1'b0, 8'd1, 1'b0, 10'd0);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      no_idle = (p % 4 == 3);
      random_config();
      queue_traffic(100);
      wait_idle();
    end

    if (errors == 0 && midi_due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
